// File: rtl/pfpd_pkg.sv
// Shared types, constants and the duty window decoder of the pump feedback diagnosis.
package pfpd_pkg;

    // Configuration register indexes
    localparam logic REG_INHIBIT_DELAY = 1'b0;
    localparam logic REG_RECOVERY      = 1'b1;

    // Field widths
    localparam int DUTY_RAW_W   = 16;
    localparam int PERIOD_RAW_W = 32;
    localparam int DUTY_W       = 10;
    localparam int PERIOD_W     = 17;
    localparam int FREQ_W       = 8;
    localparam int STATUS_W     = 4;
    localparam int CFG_W        = 8;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 48;

    // Serial divider sizing: two quotient bits per step
    localparam int DIV_W        = 32;
    localparam int DIVISOR_W    = 17;
    localparam int DIV_STEP_W   = 5;
    localparam logic [DIV_STEP_W-1:0] STEPS_PERIOD = 5'd16;
    localparam logic [DIV_STEP_W-1:0] STEPS_FREQ   = 5'd10;

    // Arithmetic constants
    localparam logic [DIVISOR_W-1:0] PERIOD_DIVISOR = 17'd100;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX     = 17'd100000;
    // 1000000 left aligned so that ten steps yield its 20-bit quotient
    localparam logic [DIV_W-1:0]     FREQ_DIVIDEND  = 32'hF424_0000;
    localparam logic [FREQ_W-1:0]    FREQ_MAX       = 8'd200;
    localparam logic [FREQ_W-1:0]    FREQ_LOW       = 8'd70;
    localparam logic [FREQ_W-1:0]    FREQ_HIGH      = 8'd130;
    localparam logic [DUTY_W-1:0]    DUTY_MAX       = 10'd1000;
    localparam logic [6:0]           DUTY_GAIN      = 7'd125;
    localparam logic [22:0]          DUTY_ROUND     = 23'd2048;

    // Status codes
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_0 = 4'd0;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_1 = 4'd1;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_2 = 4'd2;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_3 = 4'd3;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_4 = 4'd4;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_5 = 4'd5;
    localparam logic [STATUS_W-1:0] CODE_NOMINAL_6 = 4'd6;
    localparam logic [STATUS_W-1:0] CODE_SHORT     = 4'd7;
    localparam logic [STATUS_W-1:0] CODE_SATURATED = 4'd8;
    localparam logic [STATUS_W-1:0] CODE_MAP       = 4'd9;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIVP = 4'b0010,
        ST_DIVF = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Divider launch request
    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    // Map a per mille duty onto its window code
    function automatic logic [STATUS_W-1:0] decode_duty(input logic [DUTY_W-1:0] d);
        logic [STATUS_W-1:0] c;
        begin
            if (d <= 10'd20 || (d >= 10'd980 && d <= 10'd1000)) c = CODE_SATURATED;
            else if (d >= 10'd70  && d <= 10'd150) c = CODE_NOMINAL_0;
            else if (d >= 10'd180 && d <= 10'd260) c = CODE_NOMINAL_1;
            else if (d >= 10'd290 && d <= 10'd370) c = CODE_NOMINAL_2;
            else if (d >= 10'd400 && d <= 10'd480) c = CODE_NOMINAL_3;
            else if (d >= 10'd510 && d <= 10'd590) c = CODE_NOMINAL_4;
            else if (d >= 10'd620 && d <= 10'd700) c = CODE_NOMINAL_5;
            else if (d >= 10'd730 && d <= 10'd810) c = CODE_NOMINAL_6;
            else if (d >= 10'd840 && d <= 10'd920) c = CODE_SHORT;
            else c = CODE_MAP;
            return c;
        end
    endfunction

endpackage

// File: rtl/pump_feedback_pwm_diagnosis_core.sv
// Top level of the pump feedback PWM diagnosis: sequencer, delay gate, faults and status.
//
//  Channel  | Ports                          | Content
//  ---------+--------------------------------+------------------------------------------
//  input    | i_s_tvalid/o_s_tready/i_s_tdata | one measurement item per control tick
//  output   | o_m_tvalid/i_m_tready/o_m_tdata | status, faults, frequency, scaled values
//  config   | i_cfg_we/i_cfg_addr/i_cfg_data  | inhibit delay ticks, recovery status
//
// An item runs from acceptance to a valid result through the serial divider for
// period/100 (two quotient bits a cycle over 32 bits), the launch of the frequency
// division, the frequency quotient, the latch of that quotient and the write-back.
// The next item is taken once the result sits in the output register, even if the
// output side stalls; a stalled output holds the following write-back.
// Synchronous active-low reset clears all control state and the held diagnosis.
module pump_feedback_pwm_diagnosis_core
    import pfpd_pkg::*;
#(
    parameter int DELAY_LIMIT = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // duty_raw[15:0], period_raw[31:0], relay_closed, diag_inhibited, default_mode
    // from bit 0 up
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // pump_status[3:0], diag_enabled, fault_frequency, fault_map, fault_short_battery,
    // frequency[7:0], duty_permille[9:0], period_scaled[16:0] from bit 0 up
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_delay;
    logic [CFG_W-1:0] r_cfg_recovery;

    // Latched item
    logic [DUTY_RAW_W-1:0] r_duty_raw;
    logic                  r_relay, r_inh, r_dflt;
    logic [PERIOD_W-1:0]   r_period;
    logic [FREQ_W-1:0]     r_freq;

    // Diagnosis state
    logic                r_relay_prev, n_relay_prev;
    logic [7:0]          r_delay_cnt, n_delay_cnt;
    logic                r_delay_done, n_delay_done;
    logic                r_ff, n_ff;
    logic                r_fm, n_fm;
    logic                r_fs, n_fs;
    logic [FREQ_W-1:0]   r_hfreq, n_hfreq;
    logic [STATUS_W-1:0] r_last, n_last;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Divider hookup
    t_div_req              div_req;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;

    logic                  in_acc;
    logic                  out_load;
    logic [PERIOD_W-1:0]   period_clamped;
    logic [FREQ_W-1:0]     freq_clamped;
    logic [22:0]           duty_prod;
    logic [DUTY_W-1:0]     duty;
    logic [STATUS_W-1:0]   code;
    logic [7:0]            delay_load;
    logic                  enabled;
    logic [STATUS_W-1:0]   cand;
    logic [STATUS_W-1:0]   rec_clamped;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    // Launch period scaling on accept, frequency once the period is known
    always_comb begin
        div_req.start = in_acc || ((r_state == ST_DIVP) && div_done);
        div_req.steps = (r_state == ST_IDLE) ? STEPS_PERIOD : STEPS_FREQ;
        div_dividend  = (r_state == ST_IDLE) ? i_s_tdata[47:16] : FREQ_DIVIDEND;
        div_divisor   = (r_state == ST_IDLE) ? PERIOD_DIVISOR : period_clamped;
    end

    pfpd_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Clamp the quotients
    assign period_clamped = (div_quo > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                            : div_quo[PERIOD_W-1:0];
    assign freq_clamped   = (div_quo > DIV_W'(FREQ_MAX)) ? FREQ_MAX : div_quo[FREQ_W-1:0];

    // Scale duty to per mille and decode
    assign duty_prod = 23'(r_duty_raw) * 23'(DUTY_GAIN) + DUTY_ROUND;
    assign duty      = (duty_prod[22:12] > 11'(DUTY_MAX)) ? DUTY_MAX : duty_prod[21:12];
    assign code      = decode_duty(duty);

    assign delay_load  = (r_cfg_delay > 8'(DELAY_LIMIT)) ? 8'(DELAY_LIMIT) : r_cfg_delay;
    assign rec_clamped = (r_cfg_recovery > 8'(CODE_SATURATED)) ? CODE_SATURATED
                                                               : r_cfg_recovery[3:0];

    // Delay gate, fault latches and status selection
    always_comb begin
        n_relay_prev = r_relay;
        n_delay_cnt  = r_delay_cnt;
        n_delay_done = r_delay_done;
        if (!r_relay_prev && r_relay) begin
            n_delay_cnt  = delay_load;
            n_delay_done = (delay_load == 8'd0);
        end else if (r_delay_cnt != 8'd0) begin
            n_delay_cnt  = r_delay_cnt - 8'd1;
            n_delay_done = (r_delay_cnt == 8'd1);
        end
        enabled = !r_inh && r_relay && n_delay_done;

        n_ff    = r_ff;
        n_fm    = r_fm;
        n_fs    = r_fs;
        n_hfreq = r_hfreq;
        if (enabled) begin
            n_fs    = (code == CODE_SHORT);
            n_fm    = (code == CODE_MAP);
            n_hfreq = r_freq;
            n_ff    = (r_freq < FREQ_LOW) || (r_freq > FREQ_HIGH);
        end

        // Freeze on any fault or inhibit
        cand = (!n_ff && !n_fm && !n_fs && !r_inh) ? code : r_last;
        if (r_dflt) begin
            n_last = rec_clamped;
        end else begin
            n_last = (cand > CODE_SATURATED) ? CODE_SATURATED : cand;
        end

        n_out_data = {5'b0, r_period, duty, n_hfreq, n_fs, n_fm, n_ff, enabled, n_last};
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc)   n_state = ST_DIVP;
            ST_DIVP: if (div_done) n_state = ST_DIVF;
            ST_DIVF: if (div_done) n_state = ST_DONE;
            ST_DONE: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cfg_delay    <= '0;
            r_cfg_recovery <= '0;
            r_relay_prev   <= 1'b0;
            r_delay_cnt    <= '0;
            r_delay_done   <= 1'b0;
            r_ff           <= 1'b0;
            r_fm           <= 1'b0;
            r_fs           <= 1'b0;
            r_hfreq        <= '0;
            r_last         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_INHIBIT_DELAY: r_cfg_delay    <= i_cfg_data;
                    REG_RECOVERY:      r_cfg_recovery <= i_cfg_data;
                    default:           r_cfg_delay    <= r_cfg_delay;
                endcase
            end
            // Commit diagnosis state with the result
            if (out_load) begin
                r_relay_prev <= n_relay_prev;
                r_delay_cnt  <= n_delay_cnt;
                r_delay_done <= n_delay_done;
                r_ff         <= n_ff;
                r_fm         <= n_fm;
                r_fs         <= n_fs;
                r_hfreq      <= n_hfreq;
                r_last       <= n_last;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end

        // Payload registers
        if (in_acc) begin
            r_duty_raw <= i_s_tdata[15:0];
            r_relay    <= i_s_tdata[48];
            r_inh      <= i_s_tdata[49];
            r_dflt     <= i_s_tdata[50];
        end
        if ((r_state == ST_DIVP) && div_done) begin
            r_period <= period_clamped;
        end
        if ((r_state == ST_DIVF) && div_done) begin
            r_freq <= (r_period == '0) ? '0 : freq_clamped;
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: rtl/pfpd_serdiv.sv
// Restoring serial divider, two quotient bits per cycle, shared by both divisions.
module pfpd_serdiv
    import pfpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    input  logic [DIV_W-1:0]     i_dividend,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_W-1:0]     o_quotient
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_STEP_W-1:0] r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [DIV_W-1:0]      r_dvd, n_dvd;
    logic [DIV_W-1:0]      r_quo, n_quo;

    logic [DIVISOR_W:0]    t1, t2, r1, r2;
    logic                  s1, s2;

    // Two shift-compare-subtract substeps
    always_comb begin
        t1 = {r_rem, r_dvd[DIV_W-1]};
        s1 = (t1 >= {1'b0, r_div});
        r1 = s1 ? (t1 - {1'b0, r_div}) : t1;
        t2 = {r1[DIVISOR_W-1:0], r_dvd[DIV_W-2]};
        s2 = (t2 >= {1'b0, r_div});
        r2 = s2 ? (t2 - {1'b0, r_div}) : t2;
    end

    // Load on request, then advance one digit a cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = '0;
            n_div  = i_divisor;
            n_dvd  = i_dividend;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = r2[DIVISOR_W-1:0];
            n_dvd = {r_dvd[DIV_W-3:0], 2'b00};
            n_quo = {r_quo[DIV_W-3:0], s1, s2};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/pfpd_checker.sv
// Port-level checker for the pump feedback diagnosis core, with its bind.
module pfpd_checker
    import pfpd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata
);

    // An accepted item keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input ready right after an accepted item");

    // Status never exceeds the saturated code
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[3:0] <= CODE_SATURATED))
        else $error("pump status above saturation code");

    // A diagnosis run leaves the frequency fault consistent with the frequency
    a_freq_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[4]) |->
            (i_m_tdata[5] == ((i_m_tdata[15:8] < FREQ_LOW) || (i_m_tdata[15:8] > FREQ_HIGH))))
        else $error("frequency fault disagrees with frequency");

    // Frequency stays within its clamp
    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[15:8] <= FREQ_MAX))
        else $error("frequency above clamp");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind pump_feedback_pwm_diagnosis_core pfpd_checker u_pfpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
